// File: design/hbpc_pkg.sv
// ----------------------------------------------------------------------------
// hbpc_pkg
// Types, constants and tables for the holonomic base P controller.
// ----------------------------------------------------------------------------
package hbpc_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int ATAN_ENTRIES = 24;
  localparam int CORDIC_ITERS = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
  localparam int CNT_W        = 5;

  localparam int PAYLOAD_W    = 160;
  localparam int RESULT_W     = 48;
  localparam int CFG_W        = 20;
  localparam int CFG_IDX_W    = 3;
  localparam int MUL1_BITS    = 18;
  localparam int GAIN_BITS    = 16;

  localparam logic signed [17:0] TWO_PI_Q13  = 18'sd51472;
  localparam logic signed [17:0] PI_Q13      = 18'sd25736;
  localparam logic signed [31:0] PI_Q28      = 32'sd843314857;
  localparam logic signed [31:0] HALF_PI_Q28 = 32'sd421657428;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  localparam logic [CFG_IDX_W-1:0] REG_XY_TOL   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HDG_TOL  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_P_GAIN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LIN_LIM  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ANG_LIM  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LIN_STEP = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ANG_STEP = 3'd6;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROT,
    ST_ROUND,
    ST_MUL1,
    ST_SCALE,
    ST_MUL2,
    ST_DONE
  } state_t;

  function automatic logic [31:0] atan_q28(input logic [CNT_W-1:0] i);
    logic [31:0] v;
    unique case (i)
      5'd0:  v = 32'd210828714;
      5'd1:  v = 32'd124459457;
      5'd2:  v = 32'd65760959;
      5'd3:  v = 32'd33381290;
      5'd4:  v = 32'd16755422;
      5'd5:  v = 32'd8385879;
      5'd6:  v = 32'd4193963;
      5'd7:  v = 32'd2097109;
      5'd8:  v = 32'd1048571;
      5'd9:  v = 32'd524287;
      5'd10: v = 32'd262144;
      5'd11: v = 32'd131072;
      5'd12: v = 32'd65536;
      5'd13: v = 32'd32768;
      5'd14: v = 32'd16384;
      5'd15: v = 32'd8192;
      5'd16: v = 32'd4096;
      5'd17: v = 32'd2048;
      5'd18: v = 32'd1024;
      5'd19: v = 32'd512;
      5'd20: v = 32'd256;
      5'd21: v = 32'd128;
      5'd22: v = 32'd64;
      5'd23: v = 32'd32;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

// File: design/holonomic_base_p_controller_top.sv
// ----------------------------------------------------------------------------
// holonomic_base_p_controller_top
// Pose error to robot-frame velocity command: CORDIC rotation, serial
// multiplies, speed clamp and slew-rate limit.
// ----------------------------------------------------------------------------
// Channel | Direction | Contents
// in_     | slave     | tdata: poses, tuser: pose_valid
// out_    | master    | tdata: velocities, tuser: goal_reached
// cfg_    | write     | register index and data
// A valid pose runs iterative CORDIC, rounding, an 18-bit bit-serial multiply,
// scaling and a 16-bit bit-serial multiply before its result is loaded in
// ST_DONE; an invalid pose goes from ST_IDLE straight to ST_DONE. The next
// transaction is taken only after a return to ST_IDLE, so one transaction is
// in flight at a time.
// Reset is synchronous; a stalled result waits in the output register.
// ----------------------------------------------------------------------------
module holonomic_base_p_controller_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // now_x, now_y, now_heading, goal_x, goal_y, goal_heading
  input  logic [hbpc_pkg::PAYLOAD_W-1:0]    in_tdata,
  // pose_valid
  input  logic                              in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // vel_forward, vel_lateral, vel_turn
  output logic [hbpc_pkg::RESULT_W-1:0]     out_tdata,
  // goal_reached
  output logic                              out_tuser,
  input  logic                              cfg_we,
  input  logic [hbpc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [hbpc_pkg::CFG_W-1:0]        cfg_wdata
);

  hbpc_pkg::state_t state_r, state_nxt;

  logic [19:0] xy_tol_r;
  logic [14:0] hdg_tol_r;
  logic [15:0] p_gain_r;
  logic [14:0] lin_lim_r, ang_lim_r, lin_step_r, ang_step_r;

  logic signed [15:0] last_fwd_r, last_lat_r, last_turn_r;

  logic                            valid_r, flip_r;
  logic [hbpc_pkg::CNT_W-1:0]      cnt_r;
  logic signed [32:0]              ex_r, ey_r;
  logic signed [16:0]              r_r;
  logic signed [31:0]              z_r;
  logic signed [33:0]              x_r, y_r;
  logic signed [17:0]              c_r, s_r;
  logic signed [51:0]              acca_r, accb_r;
  logic signed [35:0]              dx_r, dy_r;
  logic signed [51:0]              accx_r, accy_r;
  logic signed [32:0]              acct_r;

  logic                            out_valid_r, out_reached_r;
  logic [hbpc_pkg::RESULT_W-1:0]   out_data_r;

  logic in_acc, out_load;

  // input unpacking and wrap
  logic signed [31:0] now_x, now_y, goal_x, goal_y;
  logic signed [15:0] now_h, goal_h;
  logic signed [17:0] hd, hr0, hr1;
  logic signed [31:0] z0, z1;
  logic               flip0;

  assign now_x  = in_tdata[31:0];
  assign now_y  = in_tdata[63:32];
  assign now_h  = in_tdata[79:64];
  assign goal_x = in_tdata[111:80];
  assign goal_y = in_tdata[143:112];
  assign goal_h = in_tdata[159:144];

  always_comb begin
    hd = 18'(goal_h) - 18'(now_h);
    if (hd >= hbpc_pkg::TWO_PI_Q13) hr0 = hd - hbpc_pkg::TWO_PI_Q13;
    else if (hd <= -hbpc_pkg::TWO_PI_Q13) hr0 = hd + hbpc_pkg::TWO_PI_Q13;
    else hr0 = hd;
    if (hr0 > hbpc_pkg::PI_Q13) hr1 = hr0 - hbpc_pkg::TWO_PI_Q13;
    else if (hr0 < -hbpc_pkg::PI_Q13) hr1 = hr0 + hbpc_pkg::TWO_PI_Q13;
    else hr1 = hr0;
    z0 = 32'(now_h) <<< 15;
    if (z0 > hbpc_pkg::HALF_PI_Q28) begin
      z1 = z0 - hbpc_pkg::PI_Q28; flip0 = 1'b1;
    end else if (z0 < -hbpc_pkg::HALF_PI_Q28) begin
      z1 = z0 + hbpc_pkg::PI_Q28; flip0 = 1'b1;
    end else begin
      z1 = z0; flip0 = 1'b0;
    end
  end

  // CORDIC iteration
  logic signed [33:0] shx, shy, x_it, y_it, x_fin, y_fin;
  logic signed [31:0] z_it, atan_v;

  always_comb begin
    shx    = x_r >>> cnt_r;
    shy    = y_r >>> cnt_r;
    atan_v = $signed(hbpc_pkg::atan_q28(cnt_r));
    if (z_r >= 0) begin
      x_it = x_r - shy; y_it = y_r + shx; z_it = z_r - atan_v;
    end else begin
      x_it = x_r + shy; y_it = y_r - shx; z_it = z_r + atan_v;
    end
    x_fin = flip_r ? -x_r : x_r;
    y_fin = flip_r ? -y_r : y_r;
  end

  // serial multiply terms
  logic               bc, bs, bp;
  logic signed [51:0] terma, termb, acca_nxt, accb_nxt;
  logic signed [51:0] termx, termy, accx_nxt, accy_nxt;
  logic signed [32:0] termt, acct_nxt;
  logic               first1;

  always_comb begin
    bc     = c_r[cnt_r];
    bs     = s_r[cnt_r];
    bp     = p_gain_r[cnt_r[3:0]];
    first1 = (cnt_r == hbpc_pkg::CNT_W'(hbpc_pkg::MUL1_BITS - 1));
    terma  = (bc ? 52'(ex_r) : 52'sd0) + (bs ? 52'(ey_r) : 52'sd0);
    termb  = (bc ? 52'(ey_r) : 52'sd0) - (bs ? 52'(ex_r) : 52'sd0);
    acca_nxt = first1 ? -terma : (acca_r <<< 1) + terma;
    accb_nxt = first1 ? -termb : (accb_r <<< 1) + termb;
    termx  = bp ? 52'(dx_r) : 52'sd0;
    termy  = bp ? 52'(dy_r) : 52'sd0;
    termt  = bp ? 33'(r_r) : 33'sd0;
    accx_nxt = (accx_r <<< 1) + termx;
    accy_nxt = (accy_r <<< 1) + termy;
    acct_nxt = (acct_r <<< 1) + termt;
  end

  function automatic logic signed [15:0] limit_slew(
    input logic               err_pos,
    input logic signed [35:0] v,
    input logic [14:0]        lim,
    input logic signed [15:0] old,
    input logic [14:0]        step
  );
    logic signed [36:0] vv, l, hi, lo;
    vv = 37'(v);
    l  = $signed({22'b0, lim});
    hi = 37'(old) + $signed({22'b0, step});
    lo = 37'(old) - $signed({22'b0, step});
    if (err_pos) begin
      if (vv > l) vv = l;
    end else begin
      if (vv < -l) vv = -l;
    end
    if (vv > hi) vv = hi;
    if (vv < lo) vv = lo;
    return vv[15:0];
  endfunction

  // result
  logic signed [35:0] vx, vy;
  logic signed [19:0] vt;
  logic signed [15:0] fwd, lat, turn;
  logic signed [33:0] aex, aey;
  logic signed [16:0] ar;
  logic               reached;

  always_comb begin
    vx   = 36'(accx_r >>> 16);
    vy   = 36'(accy_r >>> 16);
    vt   = 20'(acct_r >>> 13);
    fwd  = limit_slew(dx_r > 0, vx, lin_lim_r, last_fwd_r, lin_step_r);
    lat  = limit_slew(dy_r > 0, vy, lin_lim_r, last_lat_r, lin_step_r);
    turn = limit_slew(r_r > 0, 36'(vt), ang_lim_r, last_turn_r, ang_step_r);
    aex  = (ex_r < 0) ? -34'(ex_r) : 34'(ex_r);
    aey  = (ey_r < 0) ? -34'(ey_r) : 34'(ey_r);
    ar   = (r_r < 0) ? -r_r : r_r;
    reached = (aex <= $signed({14'b0, xy_tol_r})) &&
              (aey <= $signed({14'b0, xy_tol_r})) &&
              (ar <= $signed({2'b0, hdg_tol_r}));
  end

  assign in_tready = (state_r == hbpc_pkg::ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_load  = (state_r == hbpc_pkg::ST_DONE) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      hbpc_pkg::ST_IDLE:  if (in_acc) state_nxt = in_tuser ? hbpc_pkg::ST_ROT : hbpc_pkg::ST_DONE;
      hbpc_pkg::ST_ROT:   if (cnt_r == hbpc_pkg::CNT_W'(hbpc_pkg::CORDIC_ITERS - 1))
                            state_nxt = hbpc_pkg::ST_ROUND;
      hbpc_pkg::ST_ROUND: state_nxt = hbpc_pkg::ST_MUL1;
      hbpc_pkg::ST_MUL1:  if (cnt_r == '0) state_nxt = hbpc_pkg::ST_SCALE;
      hbpc_pkg::ST_SCALE: state_nxt = hbpc_pkg::ST_MUL2;
      hbpc_pkg::ST_MUL2:  if (cnt_r == '0) state_nxt = hbpc_pkg::ST_DONE;
      hbpc_pkg::ST_DONE:  if (out_load) state_nxt = hbpc_pkg::ST_IDLE;
      default:            state_nxt = hbpc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= hbpc_pkg::ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xy_tol_r   <= 20'd328;
      hdg_tol_r  <= 15'd41;
      p_gain_r   <= 16'd4915;
      lin_lim_r  <= 15'd819;
      ang_lim_r  <= 15'd819;
      lin_step_r <= 15'd55;
      ang_step_r <= 15'd55;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hbpc_pkg::REG_XY_TOL:   xy_tol_r   <= cfg_wdata;
        hbpc_pkg::REG_HDG_TOL:  hdg_tol_r  <= cfg_wdata[14:0];
        hbpc_pkg::REG_P_GAIN:   p_gain_r   <= cfg_wdata[15:0];
        hbpc_pkg::REG_LIN_LIM:  lin_lim_r  <= cfg_wdata[14:0];
        hbpc_pkg::REG_ANG_LIM:  ang_lim_r  <= cfg_wdata[14:0];
        hbpc_pkg::REG_LIN_STEP: lin_step_r <= cfg_wdata[14:0];
        hbpc_pkg::REG_ANG_STEP: ang_step_r <= cfg_wdata[14:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      hbpc_pkg::ST_IDLE: if (in_acc) begin
        valid_r <= in_tuser;
        ex_r    <= 33'(goal_x) - 33'(now_x);
        ey_r    <= 33'(goal_y) - 33'(now_y);
        r_r     <= hr1[16:0];
        z_r     <= z1;
        flip_r  <= flip0;
        x_r     <= hbpc_pkg::CORDIC_GAIN;
        y_r     <= '0;
        cnt_r   <= '0;
      end
      hbpc_pkg::ST_ROT: begin
        x_r   <= x_it;
        y_r   <= y_it;
        z_r   <= z_it;
        cnt_r <= cnt_r + 1'b1;
      end
      hbpc_pkg::ST_ROUND: begin
        c_r   <= 18'((x_fin + 34'sd8192) >>> 14);
        s_r   <= 18'((y_fin + 34'sd8192) >>> 14);
        cnt_r <= hbpc_pkg::CNT_W'(hbpc_pkg::MUL1_BITS - 1);
      end
      hbpc_pkg::ST_MUL1: begin
        acca_r <= acca_nxt;
        accb_r <= accb_nxt;
        cnt_r  <= cnt_r - 1'b1;
      end
      hbpc_pkg::ST_SCALE: begin
        dx_r   <= 36'((acca_r + 52'sd32768) >>> 16);
        dy_r   <= 36'((accb_r + 52'sd32768) >>> 16);
        accx_r <= '0;
        accy_r <= '0;
        acct_r <= '0;
        cnt_r  <= hbpc_pkg::CNT_W'(hbpc_pkg::GAIN_BITS - 1);
      end
      hbpc_pkg::ST_MUL2: begin
        accx_r <= accx_nxt;
        accy_r <= accy_nxt;
        acct_r <= acct_nxt;
        cnt_r  <= cnt_r - 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_fwd_r  <= '0;
      last_lat_r  <= '0;
      last_turn_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
        if (valid_r) begin
          last_fwd_r    <= fwd;
          last_lat_r    <= lat;
          last_turn_r   <= turn;
          out_data_r    <= {turn, lat, fwd};
          out_reached_r <= reached;
        end else begin
          out_data_r    <= '0;
          out_reached_r <= 1'b0;
        end
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_reached_r;

endmodule
